/* rtl/core/assert_macros.svh */
// Assertion macros for the RTL modules of the indexed list table, used by the sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every rising clock edge outside reset.
`define ILT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Expression must never be true at a rising clock edge outside reset.
`define ILT_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");

`else

`define ILT_ASSERT(lbl, clk, rst_n, prop)
`define ILT_ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

/* rtl/core/ilt_pkg.sv */
// Package with the sizes, codes and types of the indexed list table.
`default_nettype none

package ilt_pkg;

  // Capacity of the list and the widths that follow from it.
  localparam int unsigned CAPACITY = 16;
  localparam int unsigned IDX_W    = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  // Fixed field widths of the words on the ports.
  localparam int unsigned OP_W     = 3;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned INDEX_W  = 4;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;

  // Width in which an index field and the entry count are compared.
  localparam int unsigned CMP_W = ((CNT_W > INDEX_W) ? CNT_W : INDEX_W) + 1;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
  localparam logic [OP_W-1:0] OP_READ   = 3'd3;
  localparam logic [OP_W-1:0] OP_FIND   = 3'd4;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

  // One result word as handed from the sequencer to the output register.
  typedef struct packed {
    logic signed [VALUE_W-1:0] data;
    logic [POS_W-1:0]          position;
    logic [STATUS_W-1:0]       status;
    logic [COUNT_W-1:0]        count;
  } res_t;

endpackage

`default_nettype wire

/* rtl/core/ilt_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module ilt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 2) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, updated only when the read enable is set.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/ilt_seq.sv */
// Operation sequencer: walks the entry RAM to append, shift, read and search.
`default_nettype none
`include "assert_macros.svh"

module ilt_seq import ilt_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [OP_W-1:0]           op_i,
  input  logic signed [VALUE_W-1:0] value_i,
  input  logic [INDEX_W-1:0]        index_i,
  output logic                      ram_we_o,
  output logic [IDX_W-1:0]          ram_waddr_o,
  output logic [VALUE_W-1:0]        ram_wdata_o,
  output logic                      ram_re_o,
  output logic [IDX_W-1:0]          ram_raddr_o,
  input  logic [VALUE_W-1:0]        ram_rdata_i,
  output logic                      res_valid_o,
  output res_t                      res_o,
  input  logic                      res_stall_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT_UP,
    S_SHIFT_DN,
    S_PUT,
    S_READ,
    S_FIND,
    S_DONE
  } state_e;

  state_e               state_q, state_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [IDX_W-1:0]     ptr_q, ptr_d;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic [VALUE_W-1:0]   val_q, val_d;
  logic [VALUE_W-1:0]   data_q, data_d;
  logic [POS_W-1:0]     pos_q, pos_d;
  logic [STATUS_W-1:0]  status_q, status_d;

  logic [CMP_W-1:0]     idx_in_c;
  logic [CMP_W-1:0]     cnt_c;
  logic                 full_c;

  assign idx_in_c = CMP_W'(index_i);
  assign cnt_c    = CMP_W'(cnt_q);
  assign full_c   = (cnt_q == CNT_W'(CAPACITY));

  // Items are taken only while no operation is in flight.
  assign in_stall_o  = (state_q != S_IDLE);
  assign res_valid_o = (state_q == S_DONE);

  always_comb begin
    res_o.data     = data_q;
    res_o.position = pos_q;
    res_o.status   = status_q;
    res_o.count    = COUNT_W'(cnt_q);
  end

  // Next-state logic and RAM port control.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ptr_d       = ptr_q;
    idx_d       = idx_q;
    val_d       = val_q;
    data_d      = data_q;
    pos_d       = pos_q;
    status_d    = status_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = ptr_q;
    ram_wdata_o = ram_rdata_i;
    ram_re_o    = 1'b0;
    ram_raddr_o = ptr_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          val_d    = value_i;
          idx_d    = IDX_W'(index_i);
          data_d   = '0;
          pos_d    = '0;
          status_d = ST_OK;
          state_d  = S_DONE;
          case (op_i)
            OP_APPEND: begin
              if (full_c) begin
                status_d = ST_FULL;
              end else begin
                ram_we_o    = 1'b1;
                ram_waddr_o = IDX_W'(cnt_q);
                ram_wdata_o = value_i;
                cnt_d       = cnt_q + CNT_W'(1);
              end
            end
            OP_INSERT: begin
              if (full_c) begin
                status_d = ST_FULL;
              end else if (idx_in_c > cnt_c) begin
                status_d = ST_BAD_INDEX;
              end else if (idx_in_c == cnt_c) begin
                ram_we_o    = 1'b1;
                ram_waddr_o = IDX_W'(cnt_q);
                ram_wdata_o = value_i;
                cnt_d       = cnt_q + CNT_W'(1);
              end else begin
                // Move entries up from the top, one a cycle.
                ram_re_o    = 1'b1;
                ram_raddr_o = IDX_W'(cnt_q - CNT_W'(1));
                ptr_d       = IDX_W'(cnt_q);
                state_d     = S_SHIFT_UP;
              end
            end
            OP_REMOVE: begin
              if (idx_in_c >= cnt_c) begin
                status_d = ST_BAD_INDEX;
              end else if (idx_in_c + CMP_W'(1) == cnt_c) begin
                cnt_d = cnt_q - CNT_W'(1);
              end else begin
                // Move entries down towards the removed place.
                ram_re_o    = 1'b1;
                ram_raddr_o = IDX_W'(index_i) + IDX_W'(1);
                ptr_d       = IDX_W'(index_i);
                state_d     = S_SHIFT_DN;
              end
            end
            OP_READ: begin
              if (idx_in_c >= cnt_c) begin
                status_d = ST_BAD_INDEX;
              end else begin
                ram_re_o    = 1'b1;
                ram_raddr_o = IDX_W'(index_i);
                state_d     = S_READ;
              end
            end
            OP_FIND: begin
              if (cnt_q == '0) begin
                status_d = ST_NOT_FOUND;
              end else begin
                ram_re_o    = 1'b1;
                ram_raddr_o = '0;
                ptr_d       = '0;
                state_d     = S_FIND;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_SHIFT_UP: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = ptr_q;
        ram_wdata_o = ram_rdata_i;
        if (ptr_q - IDX_W'(1) == idx_q) begin
          state_d = S_PUT;
        end else begin
          ram_re_o    = 1'b1;
          ram_raddr_o = ptr_q - IDX_W'(1) - IDX_W'(1);
          ptr_d       = ptr_q - IDX_W'(1);
        end
      end

      S_PUT: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = idx_q;
        ram_wdata_o = val_q;
        cnt_d       = cnt_q + CNT_W'(1);
        state_d     = S_DONE;
      end

      S_SHIFT_DN: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = ptr_q;
        ram_wdata_o = ram_rdata_i;
        if (CMP_W'(ptr_q) + CMP_W'(2) == cnt_c) begin
          cnt_d   = cnt_q - CNT_W'(1);
          state_d = S_DONE;
        end else begin
          ram_re_o    = 1'b1;
          ram_raddr_o = ptr_q + IDX_W'(1) + IDX_W'(1);
          ptr_d       = ptr_q + IDX_W'(1);
        end
      end

      S_READ: begin
        data_d  = ram_rdata_i;
        state_d = S_DONE;
      end

      S_FIND: begin
        // Compare the word read last cycle and fetch the next one.
        if (ram_rdata_i == val_q) begin
          pos_d    = POS_W'(ptr_q);
          status_d = ST_OK;
          state_d  = S_DONE;
        end else if (CMP_W'(ptr_q) + CMP_W'(1) == cnt_c) begin
          status_d = ST_NOT_FOUND;
          state_d  = S_DONE;
        end else begin
          ram_re_o    = 1'b1;
          ram_raddr_o = ptr_q + IDX_W'(1);
          ptr_d       = ptr_q + IDX_W'(1);
        end
      end

      S_DONE: begin
        if (!res_stall_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      ptr_q    <= '0;
      idx_q    <= '0;
      val_q    <= '0;
      data_q   <= '0;
      pos_q    <= '0;
      status_q <= ST_OK;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      ptr_q    <= ptr_d;
      idx_q    <= idx_d;
      val_q    <= val_d;
      data_q   <= data_d;
      pos_q    <= pos_d;
      status_q <= status_d;
    end
  end

  // The entry count never passes the capacity.
  `ILT_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= CNT_W'(CAPACITY))
  // An accepted word always starts an operation.
  `ILT_ASSERT(a_accept_busy, clk_i, rst_ni, (in_valid_i && !in_stall_o) |=> (state_q != S_IDLE))
  // The count moves by at most one per operation step.
  `ILT_ASSERT(a_cnt_step, clk_i, rst_ni, (cnt_q != $past(cnt_q)) |-> ((cnt_q == $past(cnt_q) + CNT_W'(1)) || (cnt_q == $past(cnt_q) - CNT_W'(1))))
  // No entry is written while a result waits for hand-off.
  `ILT_ASSERT_NEVER(a_no_write_done, clk_i, rst_ni, ram_we_o && (state_q == S_DONE))

endmodule

`default_nettype wire

/* rtl/core/indexed_list_table.sv */
// Top level of the indexed list table: sequencer, entry RAM and output register.
//
//   Channel  Direction  Handshake                 Fields
//   in       input      in_valid_i / in_stall_o   op_i, value_i, index_i
//   out      output     out_valid_o / out_stall_i data_o, position_o, status_o, count_o
//
// One operation is in flight at a time; the entry RAM moves one entry per cycle.
// Append, insert at the count, and failed or unused operations go straight to the result;
// read waits for its RAM word, remove and insert shift the entries above the index one at
// a time, and find scans from position 0 up to the first match or the count.
// Reset clears the count and control state at once; no clearing pass is needed.
// A stalled output holds its word while the next operation runs behind it.
`default_nettype none

module indexed_list_table import ilt_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [OP_W-1:0]            op_i,
  input  logic signed [VALUE_W-1:0]  value_i,
  input  logic [INDEX_W-1:0]         index_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [VALUE_W-1:0]  data_o,
  output logic [POS_W-1:0]           position_o,
  output logic [STATUS_W-1:0]        status_o,
  output logic [COUNT_W-1:0]         count_o
);

  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic [VALUE_W-1:0]  ram_wdata;
  logic                ram_re;
  logic [IDX_W-1:0]    ram_raddr;
  logic [VALUE_W-1:0]  ram_rdata;

  logic                res_valid;
  logic                res_stall;
  res_t                res;

  logic                out_valid_q, out_valid_d;
  res_t                out_q, out_d;
  logic                load;

  // Operation sequencer.
  ilt_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .value_i     (value_i),
    .index_i     (index_i),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_stall_i (res_stall)
  );

  // Entry store.
  ilt_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Output register: takes a new result when empty or being drained.
  assign res_stall   = out_valid_q && out_stall_i;
  assign load        = res_valid && !res_stall;
  assign out_valid_d = load || (out_valid_q && out_stall_i);
  assign out_d       = load ? res : out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign data_o      = out_q.data;
  assign position_o  = out_q.position;
  assign status_o    = out_q.status;
  assign count_o     = out_q.count;

endmodule

`default_nettype wire

/* tb/ilt_result_check.sv */
`timescale 1ns / 1ps
// Result checker for the indexed list table: mirrors the list and compares every result word.

module ilt_result_check import ilt_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_stall_i,
  input  logic [OP_W-1:0]           op_i,
  input  logic signed [VALUE_W-1:0] value_i,
  input  logic [INDEX_W-1:0]        index_i,
  input  logic                      out_valid_i,
  input  logic                      out_stall_i,
  input  logic signed [VALUE_W-1:0] data_i,
  input  logic [POS_W-1:0]          position_i,
  input  logic [STATUS_W-1:0]       status_i,
  input  logic [COUNT_W-1:0]        count_i,
  output int unsigned               fail_count_o,
  output int unsigned               pending_o,
  output int unsigned               list_len_o,
  output int unsigned               n_ok_o,
  output int unsigned               n_full_o,
  output int unsigned               n_bad_o,
  output int unsigned               n_miss_o
);

  // Mirror of the list contents and its length.
  logic signed [VALUE_W-1:0] list_mem [CAPACITY];
  int unsigned               list_len;

  // Results still owed by the block, oldest first.
  res_t        pending_results [$];
  res_t        oldest;
  int unsigned fail_count;
  int unsigned words_out;
  int unsigned status_tally [4];

  assign fail_count_o = fail_count;
  assign n_ok_o       = status_tally[ST_OK];
  assign n_full_o     = status_tally[ST_FULL];
  assign n_bad_o      = status_tally[ST_BAD_INDEX];
  assign n_miss_o     = status_tally[ST_NOT_FOUND];

  // Print one mismatch line and count it.
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: result word %0d, %s: got 'h%0h, expected 'h%0h",
             $time, words_out, what, got, want);
    fail_count++;
  endtask

  // Apply one operation to the mirror and return the result word it should give.
  function automatic res_t apply_list_op(input logic [OP_W-1:0] op,
                                         input logic signed [VALUE_W-1:0] val,
                                         input logic [INDEX_W-1:0] idx);
    res_t r;
    int   j;
    bit   hit;
    r   = '0;
    hit = 1'b0;
    case (op)
      OP_APPEND: begin
        if (list_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          list_mem[list_len] = val;
          list_len++;
        end
      end
      OP_INSERT: begin
        // A full list is reported before a bad index is looked at.
        if (list_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else if (idx > list_len) begin
          r.status = ST_BAD_INDEX;
        end else begin
          for (j = int'(list_len); j > int'(idx); j--) list_mem[j] = list_mem[j-1];
          list_mem[idx] = val;
          list_len++;
        end
      end
      OP_REMOVE: begin
        if (idx >= list_len) begin
          r.status = ST_BAD_INDEX;
        end else begin
          for (j = int'(idx); j + 1 < int'(list_len); j++) list_mem[j] = list_mem[j+1];
          list_len--;
        end
      end
      OP_READ: begin
        if (idx >= list_len) r.status = ST_BAD_INDEX;
        else r.data = list_mem[idx];
      end
      OP_FIND: begin
        // Only the first matching position counts.
        r.status = ST_NOT_FOUND;
        for (j = 0; j < int'(list_len); j++) begin
          if (!hit && list_mem[j] == val) begin
            hit        = 1'b1;
            r.position = j[POS_W-1:0];
            r.status   = ST_OK;
          end
        end
      end
      default: begin
        // Spare op codes leave the list alone and report success.
      end
    endcase
    r.count = list_len[COUNT_W-1:0];
    return r;
  endfunction

  initial begin
    fail_count = 0;
    words_out  = 0;
    foreach (status_tally[k]) status_tally[k] = 0;
  end

  // Compare each accepted result word first, then predict for each accepted input word.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      list_len = 0;
      pending_results.delete();
      pending_o  <= 0;
      list_len_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected word, data", data_i, '0);
        end else begin
          oldest = pending_results.pop_front();
          if (data_i !== oldest.data) report_mismatch("data", data_i, oldest.data);
          if (position_i !== oldest.position)
            report_mismatch("position", position_i, oldest.position);
          if (status_i !== oldest.status) report_mismatch("status", status_i, oldest.status);
          if (count_i !== oldest.count) report_mismatch("count", count_i, oldest.count);
          status_tally[oldest.status]++;
        end
        words_out++;
      end
      if (in_valid_i && !in_stall_i)
        pending_results.push_back(apply_list_op(op_i, value_i, index_i));
      pending_o  <= pending_results.size();
      list_len_o <= list_len;
    end
  end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Testbench top for the indexed list table: stimulus, handshake pacing and verdict.

module tb_top;
  import ilt_pkg::*;

  // Spare op codes that the block must treat as no-ops.
  localparam logic [OP_W-1:0] OP_RSVD_5 = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;

  localparam int RANDOM_WORDS = 1350;
  localparam int HOLD_AT      = 500;
  localparam int HOLD_CYCLES  = 400;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 40;

  logic clk = 1'b0;
  logic rst_n;

  logic                      in_valid;
  logic                      in_stall;
  logic [OP_W-1:0]           in_op;
  logic signed [VALUE_W-1:0] in_value;
  logic [INDEX_W-1:0]        in_index;
  logic                      out_valid;
  logic                      out_stall;
  logic signed [VALUE_W-1:0] out_data;
  logic [POS_W-1:0]          out_position;
  logic [STATUS_W-1:0]       out_status;
  logic [COUNT_W-1:0]        out_count;

  int unsigned fail_count, pending, list_len;
  int unsigned n_ok, n_full, n_bad, n_miss;
  int unsigned sent_words, directed_words, input_stall_cycles;
  int          burst_left;

  always #2 clk = ~clk;

  indexed_list_table dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .op_i        (in_op),
    .value_i     (in_value),
    .index_i     (in_index),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .data_o      (out_data),
    .position_o  (out_position),
    .status_o    (out_status),
    .count_o     (out_count)
  );

  ilt_result_check result_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .op_i         (in_op),
    .value_i      (in_value),
    .index_i      (in_index),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .data_i       (out_data),
    .position_i   (out_position),
    .status_i     (out_status),
    .count_i      (out_count),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .list_len_o   (list_len),
    .n_ok_o       (n_ok),
    .n_full_o     (n_full),
    .n_bad_o      (n_bad),
    .n_miss_o     (n_miss)
  );

  // Values are mostly drawn from a small pool so that finds hit and repeats occur.
  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return -32'sd1;
      3:       return 32'sd0;
      4:       return 32'sh5555_5555;
      5:       return 32'shAAAA_AAAA;
      6:       return 32'sd7;
      default: return $urandom;
    endcase
  endfunction

  // Indices are biased towards the valid range and the count boundary.
  function automatic logic [INDEX_W-1:0] pick_index(input int unsigned len);
    int k;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: k = $urandom_range(0, (len > 15) ? 15 : len);
      6, 7, 8:          k = int'(len) + int'($urandom_range(0, 2)) - 1;
      default:          k = $urandom_range(0, 15);
    endcase
    if (k < 0) k = 0;
    if (k > 15) k = 15;
    return k[INDEX_W-1:0];
  endfunction

  // Operation mix depends on whether the list is meant to grow or shrink.
  function automatic logic [OP_W-1:0] pick_op(input bit grow);
    int w;
    w = $urandom_range(0, 99);
    if (w >= 98) begin
      case ($urandom_range(0, 2))
        0:       return OP_RSVD_5;
        1:       return OP_RSVD_6;
        default: return OP_RSVD_7;
      endcase
    end
    if (grow) begin
      if (w < 35) return OP_APPEND;
      if (w < 65) return OP_INSERT;
      if (w < 75) return OP_REMOVE;
      if (w < 86) return OP_READ;
      return OP_FIND;
    end
    if (w < 10) return OP_APPEND;
    if (w < 20) return OP_INSERT;
    if (w < 58) return OP_REMOVE;
    if (w < 78) return OP_READ;
    return OP_FIND;
  endfunction

  // Offer one input word, hold it until accepted, then maybe end the burst with a gap.
  task automatic send_word(input logic [OP_W-1:0] op, input logic signed [VALUE_W-1:0] val,
                           input logic [INDEX_W-1:0] idx);
    int gap;
    in_op    <= op;
    in_value <= val;
    in_index <= idx;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sent_words++;
    burst_left--;
    if (burst_left <= 0) begin
      case ($urandom_range(0, 9))
        0, 1, 2: gap = 0;
        9:       gap = $urandom_range(20, 30);
        default: gap = $urandom_range(1, 12);
      endcase
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Receiver pacing: one long hold-off, otherwise a changing stall pattern.
  initial begin : receiver
    int  mode, mode_left, hold_left, in_seen, cyc;
    bit  hold_done;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    in_seen = 0;
    cyc = 0;
    hold_done = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (in_valid && !in_stall) in_seen++;
      if (!hold_done && in_seen >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (mode_left <= 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 150);
        end
        mode_left--;
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ((cyc % 5) < 2);
        endcase
      end
    end
  end

  // Watchdog: the run fails if neither channel moves a word for too long.
  initial begin : watchdog
    int idle;
    idle = 0;
    input_stall_cycles = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
      else idle++;
      if (in_valid && in_stall) input_stall_cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // Stimulus: directed corner cases, then phased random traffic, then the verdict.
  initial begin : stimulus
    int          n, c, phase_left;
    bit          grow;
    logic [OP_W-1:0] o;
    logic signed [VALUE_W-1:0] v;
    sent_words = 0;
    burst_left = $urandom_range(1, 40);
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_op    <= OP_APPEND;
    in_value <= '0;
    in_index <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty list: out-of-range read and remove, a find that misses, spare codes, an insert past the count.
    send_word(OP_READ, 32'sd0, 4'd0);
    send_word(OP_REMOVE, 32'sd0, 4'd0);
    send_word(OP_FIND, 32'sd0, 4'd0);
    send_word(OP_RSVD_5, $urandom, 4'd15);
    send_word(OP_RSVD_6, $urandom, 4'd0);
    send_word(OP_RSVD_7, $urandom, 4'd7);
    send_word(OP_INSERT, 32'sd9, 4'd1);

    // Extreme values, insert at the front, at the count and in the middle.
    send_word(OP_APPEND, 32'sh7FFF_FFFF, 4'd0);
    send_word(OP_APPEND, 32'sh8000_0000, 4'd0);
    send_word(OP_INSERT, -32'sd1, 4'd0);
    send_word(OP_INSERT, 32'sd0, 4'd3);
    send_word(OP_INSERT, 32'sh5555_5555, 4'd2);

    // Fill the list to capacity.
    for (c = 5; c < int'(CAPACITY); c++) begin
      if (c % 2 == 0) send_word(OP_APPEND, $urandom, 4'd0);
      else send_word(OP_INSERT, pick_value(), 4'($urandom_range(0, c)));
    end

    // Full list: both adds are refused; reads at the ends and finds of two extreme values.
    send_word(OP_APPEND, 32'sd1, 4'd0);
    send_word(OP_INSERT, 32'sd1, 4'd15);
    send_word(OP_READ, 32'sd0, 4'd15);
    send_word(OP_READ, 32'sd0, 4'd0);
    send_word(OP_FIND, -32'sd1, 4'd0);
    send_word(OP_FIND, 32'sh8000_0000, 4'd0);

    // Remove the last, the first and a middle entry, then read past the new count.
    send_word(OP_REMOVE, 32'sd0, 4'd15);
    send_word(OP_REMOVE, 32'sd0, 4'd0);
    send_word(OP_REMOVE, 32'sd0, 4'd7);
    send_word(OP_READ, 32'sd0, 4'd13);
    directed_words = sent_words;

    // Random traffic in growing and shrinking phases.
    grow = 1'b1;
    phase_left = $urandom_range(30, 120);
    for (n = 0; n < RANDOM_WORDS; n++) begin
      if (phase_left <= 0 || (grow && list_len >= CAPACITY && $urandom_range(0, 7) == 0) ||
          (!grow && list_len == 0 && $urandom_range(0, 3) == 0)) begin
        grow = !grow;
        phase_left = $urandom_range(30, 120);
      end
      phase_left--;
      o = pick_op(grow);
      if (o == OP_APPEND || o == OP_INSERT || o == OP_FIND) v = pick_value();
      else v = $urandom;
      send_word(o, v, pick_index(list_len));
    end
    in_valid <= 1'b0;

    // Wait for every owed result, then let the block settle.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d directed and %0d random words; input stalled for %0d cycles.",
             directed_words, sent_words - directed_words, input_stall_cycles);
    $display("Result statuses: ok %0d, full %0d, bad index %0d, not found %0d.",
             n_ok, n_full, n_bad, n_miss);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* indexed_list_table.f */
+incdir+rtl/core
rtl/core/ilt_pkg.sv
rtl/core/ilt_ram.sv
rtl/core/ilt_seq.sv
rtl/core/indexed_list_table.sv
tb/ilt_result_check.sv
tb/tb_top.sv
